/* rtl/core/vdt_pkg.sv */
// Shared widths, constants and register indexes of the view direction update block.
package vdt_pkg;

  // Field widths
  localparam int DW     = 16;
  localparam int IW     = 8;
  localparam int CFG_AW = 2;

  // Fixed-point format
  localparam int FRAC_BITS = 14;

  localparam longint ONE_Q   = longint'(1) << FRAC_BITS;
  localparam longint SPEED_Q = ((longint'(15) << FRAC_BITS) + 500) / 1000;
  localparam longint CLAMP_Q = ((longint'(99) << FRAC_BITS) + 50) / 100;

  // Register indexes
  localparam logic [CFG_AW-1:0] REG_UP_X = 2'd0;
  localparam logic [CFG_AW-1:0] REG_UP_Y = 2'd1;
  localparam logic [CFG_AW-1:0] REG_UP_Z = 2'd2;

  // Turn and tilt offsets: SPEED_Q * 128 stays below 2^(FRAC_BITS+1)
  localparam int KW = FRAC_BITS + 2;

  // Working vector component: old direction plus the turn offset, or a unit
  // component plus the tilt offset
  localparam int VW_A = 2 * DW - FRAC_BITS + 1;
  localparam int VW_B = (VW_A > DW) ? VW_A : DW;
  localparam int VW   = ((VW_B > FRAC_BITS + 2) ? VW_B : FRAC_BITS + 2) + 1;

  // Sideways vector component: difference of two full products
  localparam int LW = 2 * DW + 1;

  // Shared multiplier operands and product
  localparam int AW = (LW > VW) ? LW : VW;
  localparam int BW = (KW > VW) ? KW : VW;
  localparam int PW = AW + BW;

  // Squared length, its root, quotient and dividend widths
  localparam int SW = 2 * VW;
  localparam int RW = VW;
  localparam int QW = FRAC_BITS + 2;
  localparam int NW = VW + FRAC_BITS + 1;

endpackage

/* rtl/core/vdt_isqrt.sv */
// Bit-serial integer square root: one root bit per cycle, two radicand bits per step.
module vdt_isqrt (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [vdt_pkg::SW-1:0] rad,
  output logic [vdt_pkg::RW-1:0] root,
  output logic                   done
);

  localparam int SW = vdt_pkg::SW;
  localparam int RW = vdt_pkg::RW;
  localparam int CW = $clog2(RW + 1);

  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [SW-1:0] rad_r;
  logic [RW:0]   rem_r;
  logic [RW-1:0] root_r;

  logic [RW+2:0] rem2;
  logic [RW+2:0] trial;
  logic [RW+2:0] diff;
  logic          ge;

  always_comb begin
    rem2  = {rem_r, rad_r[SW-1 -: 2]};
    trial = {1'b0, root_r, 2'b01};
    diff  = rem2 - trial;
    ge    = (rem2 >= trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(RW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
    if (start) begin
      rad_r  <= rad;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[SW-3:0], 2'b00};
      rem_r  <= ge ? diff[RW:0] : rem2[RW:0];
      root_r <= {root_r[RW-2:0], ge};
    end
  end

  assign root = root_r;
  assign done = done_r;

endmodule

/* rtl/core/vdt_div.sv */
// Bit-serial restoring divider lane: round(mag * 2^FRAC_BITS / root), one quotient bit a cycle.
module vdt_div (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [vdt_pkg::VW-1:0] mag,
  input  logic [vdt_pkg::RW-1:0] root,
  output logic [vdt_pkg::QW-1:0] quo,
  output logic                   done
);

  localparam int RW = vdt_pkg::RW;
  localparam int QW = vdt_pkg::QW;
  localparam int NW = vdt_pkg::NW;
  localparam int CW = $clog2(QW + 1);

  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [RW:0]   dvs_r;
  logic [RW:0]   rem_r;
  logic [QW-1:0] num_r;
  logic [QW-1:0] quo_r;

  logic [NW-1:0] dividend;
  logic [RW+1:0] rem2;
  logic [RW+1:0] diff;
  logic          ge;

  // Dividend 2*mag*2^FRAC_BITS + root over divisor 2*root rounds half away from zero.
  // mag never exceeds root, so the top part already sits below the divisor.
  always_comb begin
    dividend = (NW'(mag) << (vdt_pkg::FRAC_BITS + 1)) + NW'(root);
    rem2     = {rem_r, num_r[QW-1]};
    diff     = rem2 - {1'b0, dvs_r};
    ge       = (rem2 >= {1'b0, dvs_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(QW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
    if (start) begin
      dvs_r <= {root, 1'b0};
      rem_r <= (RW + 1)'(dividend[NW-1:QW]);
      num_r <= dividend[QW-1:0];
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[RW:0] : rem2[RW:0];
      num_r <= {num_r[QW-2:0], 1'b0};
      quo_r <= {quo_r[QW-2:0], ge};
    end
  end

  assign quo  = quo_r;
  assign done = done_r;

endmodule

/* rtl/core/view_direction_turn_update.sv */
// Top level of the view direction update: sequencer, shared multiplier and serial units.
//
// Usage:
//   Write the up vector (up_x, up_y, up_z, signed Q2.14) through cfg_we, cfg_addr
//   and cfg_wdata while the block is idle; each write takes effect at once.
//   Each item on the in_ channel (valid/ready) carries a turn and a tilt step.
//   The block turns the stored view direction, shifts its vertical part by
//   the tilt offset, renormalizes twice and returns the new direction on the
//   out_ channel. Steps: cross product, turn offset, then per normalization
//   length, check, square root and divide, and last the output step. A zero
//   length ends the item early and returns the old direction. One item is
//   in flight at a time: in_ready is high only while the sequencer waits for
//   an item, so a new item is taken only after the last one has gone to the
//   output register; the pace is set by the bit-serial square root and the
//   three bit-serial divider lanes that run side by side.
//   The result sits in an output register; a stalled receiver holds it there
//   while the next item is accepted and computed, and that item waits for the
//   register before it is delivered.
//   Reset (rst_n low at a clock edge) restores the up vector to +z, the view
//   direction to +y, and empties the output register.
module view_direction_turn_update (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [vdt_pkg::CFG_AW-1:0]        cfg_addr,
  input  logic [vdt_pkg::DW-1:0]            cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [vdt_pkg::IW-1:0]     in_turn_right,
  input  logic signed [vdt_pkg::IW-1:0]     in_tilt_up,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [vdt_pkg::DW-1:0]     out_x,
  output logic signed [vdt_pkg::DW-1:0]     out_y,
  output logic signed [vdt_pkg::DW-1:0]     out_z
);

  localparam int DW = vdt_pkg::DW;
  localparam int IW = vdt_pkg::IW;
  localparam int KW = vdt_pkg::KW;
  localparam int VW = vdt_pkg::VW;
  localparam int LW = vdt_pkg::LW;
  localparam int AW = vdt_pkg::AW;
  localparam int BW = vdt_pkg::BW;
  localparam int PW = vdt_pkg::PW;
  localparam int SW = vdt_pkg::SW;
  localparam int RW = vdt_pkg::RW;
  localparam int QW = vdt_pkg::QW;
  localparam int FB = vdt_pkg::FRAC_BITS;

  localparam logic signed [KW-1:0] SPEED_K = KW'(vdt_pkg::SPEED_Q);
  localparam logic signed [VW-1:0] CLAMP_V = VW'(vdt_pkg::CLAMP_Q);
  localparam logic [QW-1:0]        ONE_QW  = QW'(vdt_pkg::ONE_Q);
  localparam logic signed [DW-1:0] ONE_DW  = DW'(vdt_pkg::ONE_Q);
  localparam logic signed [PW-1:0] HALF_T  = PW'(longint'(1) << (2 * FB - 1));

  typedef logic signed [DW-1:0] comp_t;
  typedef logic signed [VW-1:0] vec_t;
  typedef logic signed [LW-1:0] side_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CROSS,
    S_TURN,
    S_SQ,
    S_CHK,
    S_SQRT,
    S_DIV,
    S_FIN
  } state_t;

  function automatic comp_t sat_dw(input vec_t v);
    logic [VW-DW:0] hi_bits;
    hi_bits = v[VW-1:DW-1];
    if (hi_bits == '0 || hi_bits == '1) begin
      sat_dw = v[DW-1:0];
    end else if (v[VW-1]) begin
      sat_dw = {1'b1, {(DW-1){1'b0}}};
    end else begin
      sat_dw = {1'b0, {(DW-1){1'b1}}};
    end
  endfunction

  // Configuration
  comp_t up_x_r, up_y_r, up_z_r;

  // Sequencer and datapath registers
  state_t            state_r, state_nxt;
  logic [2:0]        cnt_r, cnt_nxt;
  logic              pass_r, pass_nxt;
  logic              out_valid_r, out_valid_nxt;
  comp_t             dir_r [3];
  comp_t             dir_nxt [3];
  logic signed [KW-1:0] k_r, k_nxt;
  logic signed [KW-1:0] tk_r, tk_nxt;
  logic signed [PW-1:0] p_r, p_nxt;
  side_t             acc_r, acc_nxt;
  side_t             l_r [3];
  side_t             l_nxt [3];
  vec_t              vec_r [3];
  vec_t              vec_nxt [3];
  logic [SW-1:0]     s_r, s_nxt;
  comp_t             out_x_r, out_x_nxt;
  comp_t             out_y_r, out_y_nxt;
  comp_t             out_z_r, out_z_nxt;

  // Combinational helpers
  logic signed [AW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic signed [IW:0]   turn_ext, nturn, tilt_ext;
  logic signed [PW-1:0] turn_rnd;
  logic [1:0]           jdx;
  logic [1:0]           ldx;
  logic [VW-1:0]        mag [3];
  logic [QW-1:0]        quo [3];
  logic [QW-1:0]        qc  [3];
  vec_t                 qs  [3];
  vec_t                 zt, zc;
  logic [2:0]           dv_done;
  logic                 dv_done_all;
  logic                 sq_start, sq_done, dv_start;
  logic [RW-1:0]        sq_root;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_x_r <= '0;
      up_y_r <= '0;
      up_z_r <= ONE_DW;
    end else if (cfg_we) begin
      case (cfg_addr)
        vdt_pkg::REG_UP_X: up_x_r <= cfg_wdata;
        vdt_pkg::REG_UP_Y: up_y_r <= cfg_wdata;
        vdt_pkg::REG_UP_Z: up_z_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_CROSS: begin
        case (cnt_r)
          3'd0: begin mul_a = AW'(up_y_r); mul_b = BW'(dir_r[2]); end
          3'd1: begin mul_a = AW'(up_z_r); mul_b = BW'(dir_r[1]); end
          3'd2: begin mul_a = AW'(up_z_r); mul_b = BW'(dir_r[0]); end
          3'd3: begin mul_a = AW'(up_x_r); mul_b = BW'(dir_r[2]); end
          3'd4: begin mul_a = AW'(up_x_r); mul_b = BW'(dir_r[1]); end
          3'd5: begin mul_a = AW'(up_y_r); mul_b = BW'(dir_r[0]); end
          default: ;
        endcase
      end
      S_TURN: begin
        if (cnt_r < 3'd3) begin
          mul_a = AW'(l_r[cnt_r[1:0]]);
          mul_b = BW'(k_r);
        end
      end
      S_SQ: begin
        if (cnt_r < 3'd3) begin
          mul_a = AW'(vec_r[cnt_r[1:0]]);
          mul_b = BW'(vec_r[cnt_r[1:0]]);
        end
      end
      default: ;
    endcase
  end

  // Lane inputs and scaled results
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = vec_r[i][VW-1] ? VW'(-vec_r[i]) : VW'(vec_r[i]);
      qc[i]  = (quo[i] > ONE_QW) ? ONE_QW : quo[i];
      qs[i]  = vec_r[i][VW-1] ? -VW'(qc[i]) : VW'(qc[i]);
    end
    zt = qs[2] + VW'(tk_r);
    if (zt > CLAMP_V) begin
      zc = CLAMP_V;
    end else if (zt < -CLAMP_V) begin
      zc = -CLAMP_V;
    end else begin
      zc = zt;
    end
  end

  always_comb begin
    turn_ext = {in_turn_right[IW-1], in_turn_right};
    nturn    = -turn_ext;
    tilt_ext = {in_tilt_up[IW-1], in_tilt_up};
    turn_rnd = (p_r + HALF_T) >>> (2 * FB);
    jdx      = 2'(cnt_r - 3'd1);
    ldx      = 2'(cnt_r[2:1] - 2'd1);
  end

  assign dv_done_all = &dv_done;
  assign sq_start    = (state_r == S_CHK) && (s_r != '0);
  assign dv_start    = (state_r == S_SQRT) && sq_done;

  // Sequencer next state
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    pass_nxt      = pass_r;
    out_valid_nxt = out_valid_r && !out_ready;
    dir_nxt       = dir_r;
    k_nxt         = k_r;
    tk_nxt        = tk_r;
    p_nxt         = mul_a * mul_b;
    acc_nxt       = acc_r;
    l_nxt         = l_r;
    vec_nxt       = vec_r;
    s_nxt         = s_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_z_nxt     = out_z_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          k_nxt     = SPEED_K * KW'(nturn);
          tk_nxt    = SPEED_K * KW'(tilt_ext);
          cnt_nxt   = '0;
          pass_nxt  = 1'b0;
          state_nxt = S_CROSS;
        end
      end
      S_CROSS: begin
        cnt_nxt = cnt_r + 3'd1;
        // Odd counts take the first product of a pair, nonzero even counts close it
        if (cnt_r[0]) begin
          acc_nxt = p_r[LW-1:0];
        end else if (cnt_r != 3'd0) begin
          l_nxt[ldx] = acc_r - p_r[LW-1:0];
        end
        if (cnt_r == 3'd6) begin
          cnt_nxt   = '0;
          state_nxt = S_TURN;
        end
      end
      S_TURN: begin
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r != 3'd0) begin
          vec_nxt[jdx] = VW'(dir_r[jdx]) + $signed(turn_rnd[VW-1:0]);
        end
        if (cnt_r == 3'd3) begin
          cnt_nxt   = '0;
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'd1) begin
          s_nxt = p_r[SW-1:0];
        end else if (cnt_r != 3'd0) begin
          s_nxt = s_r + p_r[SW-1:0];
        end
        if (cnt_r == 3'd3) begin
          cnt_nxt   = '0;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        // Zero length: drop the item's update and return the old direction
        state_nxt = (s_r == '0) ? S_FIN : S_SQRT;
      end
      S_SQRT: begin
        if (sq_done) begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (dv_done_all) begin
          if (!pass_r) begin
            vec_nxt[0] = qs[0];
            vec_nxt[1] = qs[1];
            vec_nxt[2] = zc;
            pass_nxt   = 1'b1;
            cnt_nxt    = '0;
            state_nxt  = S_SQ;
          end else begin
            dir_nxt[0] = sat_dw(qs[0]);
            dir_nxt[1] = sat_dw(qs[1]);
            dir_nxt[2] = sat_dw(qs[2]);
            state_nxt  = S_FIN;
          end
        end
      end
      S_FIN: begin
        // Hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_x_nxt     = dir_r[0];
          out_y_nxt     = dir_r[1];
          out_z_nxt     = dir_r[2];
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      pass_r      <= 1'b0;
      out_valid_r <= 1'b0;
      dir_r[0]    <= '0;
      dir_r[1]    <= ONE_DW;
      dir_r[2]    <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pass_r      <= pass_nxt;
      out_valid_r <= out_valid_nxt;
      dir_r       <= dir_nxt;
    end
    k_r     <= k_nxt;
    tk_r    <= tk_nxt;
    p_r     <= p_nxt;
    acc_r   <= acc_nxt;
    l_r     <= l_nxt;
    vec_r   <= vec_nxt;
    s_r     <= s_nxt;
    out_x_r <= out_x_nxt;
    out_y_r <= out_y_nxt;
    out_z_r <= out_z_nxt;
  end

  vdt_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .rad   (s_r),
    .root  (sq_root),
    .done  (sq_done)
  );

  for (genvar g = 0; g < 3; g++) begin : g_lane
    vdt_div u_div (
      .clk   (clk),
      .rst_n (rst_n),
      .start (dv_start),
      .mag   (mag[g]),
      .root  (sq_root),
      .quo   (quo[g]),
      .done  (dv_done[g])
    );
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_x     = out_x_r;
  assign out_y     = out_y_r;
  assign out_z     = out_z_r;

endmodule

/* rtl/core/vdt_chk.sv */
// Port-level checker for the view direction update block, bound to the top level.
module vdt_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          cfg_we,
  input logic [vdt_pkg::CFG_AW-1:0]    cfg_addr,
  input logic [vdt_pkg::DW-1:0]        cfg_wdata,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic signed [vdt_pkg::IW-1:0] in_turn_right,
  input logic signed [vdt_pkg::IW-1:0] in_tilt_up,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [vdt_pkg::DW-1:0] out_x,
  input logic signed [vdt_pkg::DW-1:0] out_y,
  input logic signed [vdt_pkg::DW-1:0] out_z
);

  localparam int ONE = int'(vdt_pkg::ONE_Q);

  // Reset empties the output and opens the input
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("output not empty or input closed after reset");

  // One item at a time: the input closes right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input still open after an accepted item");

  // Every component of a delivered direction lies within the unit range
  a_unit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (int'(out_x) >= -ONE) && (int'(out_x) <= ONE) &&
                  (int'(out_y) >= -ONE) && (int'(out_y) <= ONE) &&
                  (int'(out_z) >= -ONE) && (int'(out_z) <= ONE))
    else $error("output component beyond unit range");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y) &&
                                $stable(out_z))
    else $error("stalled result changed or dropped");

endmodule

bind view_direction_turn_update vdt_chk u_vdt_chk (.*);
